### sv/lrs_pkg.sv
`timescale 1ns / 1ps
// lrs_pkg: shared types and constants for the line raster stepper.
// No dependencies; used by line_raster_stepper_unit, pixel_write_checker and tb.
package lrs_pkg;

    localparam int ADDR_W     = 26;   // linear pixel address width
    localparam int COLOR_W    = 16;   // pixel color width
    localparam int STRIDE_W   = 13;   // row stride register width
    localparam int CFG_IDX_W  = 2;    // config register index width
    localparam int CFG_DATA_W = 26;   // config write data width
    localparam int M_TDATA_W  = 48;   // address + color, padded to bytes

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(640);

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ROW  = 2'd1,
        KIND_COL  = 2'd2,
        KIND_BRES = 2'd3
    } line_kind_t;

endpackage

### sv/line_raster_stepper_unit.sv
`timescale 1ns / 1ps
// Line raster stepper: start/step requests in, at most one pixel write out per request.
// An accepted request passes three registered stages to m_tvalid (decode/step, multiply, add).
// Throughput one request per cycle; the line state updates in the accept cycle,
// so back-to-back steps run at full rate. Stalls only when all three stages are full.
// Reset (aresetn low, synchronous): pipeline empty, line idle, row_stride = 640,
// frame_base = 0.
// Depends on lrs_pkg.
module line_raster_stepper_unit #(
    parameter int X_BITS = 11,
    parameter int Y_BITS = 11
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata, low bit up: x_start, y_start, x_end, y_end, color, zero pad
    input  logic [((2*X_BITS+2*Y_BITS+lrs_pkg::COLOR_W+7)/8)*8-1:0] s_tdata,
    // tuser: mode (0 start a line, 1 step)
    input  logic                              s_tuser,

    // Pixel write channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata, low bit up: pixel_address, pixel_color, zero pad
    output logic [lrs_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast,   // last_pixel

    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lrs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lrs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Widest coordinate sets run length; error term needs two more bits (sign, 2x).
    localparam int M_BITS = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
    localparam int E_W    = M_BITS + 2;
    localparam int PROD_W = lrs_pkg::STRIDE_W + Y_BITS;
    localparam int PAD_W  = lrs_pkg::M_TDATA_W - lrs_pkg::ADDR_W - lrs_pkg::COLOR_W;

    //------------------------------------------------------------------
    // Configuration registers. The user must write them only while idle, so
    // the address stages may read them directly. The block does not enforce it.
    //------------------------------------------------------------------
    logic [lrs_pkg::STRIDE_W-1:0] row_stride_reg;
    logic [lrs_pkg::ADDR_W-1:0]   frame_base_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_stride_reg <= lrs_pkg::STRIDE_RESET;
            frame_base_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == lrs_pkg::CFG_ROW_STRIDE) begin
                row_stride_reg <= cfg_data[lrs_pkg::STRIDE_W-1:0];
            end else if (cfg_index == lrs_pkg::CFG_FRAME_BASE) begin
                frame_base_reg <= cfg_data[lrs_pkg::ADDR_W-1:0];
            end
        end
    end

    //------------------------------------------------------------------
    // Pipeline flow: each stage moves when the one after it is free.
    //------------------------------------------------------------------
    logic p1_valid_reg, p2_valid_reg, m_valid_reg;
    logic out_en, p2_en, p1_en, accept;

    assign out_en   = !m_valid_reg || m_tready;
    assign p2_en    = !p2_valid_reg || out_en;
    assign p1_en    = !p1_valid_reg || p2_en;
    assign s_tready = p1_en;
    assign accept   = s_tvalid && p1_en;

    //------------------------------------------------------------------
    // Line state
    //------------------------------------------------------------------
    logic [X_BITS-1:0]      cur_x_reg, cur_x_next, end_x_reg, end_x_next;
    logic [Y_BITS-1:0]      cur_y_reg, cur_y_next, end_y_reg, end_y_next;
    logic [X_BITS-1:0]      abs_dx_reg, abs_dx_next;
    logic [Y_BITS-1:0]      abs_dy_reg, abs_dy_next;
    logic signed [E_W-1:0]  err_reg, err_next;
    logic                   dir_x_neg_reg, dir_x_neg_next;
    logic                   dir_y_neg_reg, dir_y_neg_next;
    logic                   y_major_reg, y_major_next;
    logic [M_BITS-1:0]      run_left_reg, run_left_next;
    lrs_pkg::line_kind_t    kind_reg, kind_next;
    logic                   busy_reg, busy_next;
    logic [lrs_pkg::COLOR_W-1:0] color_reg, color_next;

    // Request fields
    logic [X_BITS-1:0] in_x0, in_x1;
    logic [Y_BITS-1:0] in_y0, in_y1;
    logic [lrs_pkg::COLOR_W-1:0] in_color;

    assign in_x0    = s_tdata[0 +: X_BITS];
    assign in_y0    = s_tdata[X_BITS +: Y_BITS];
    assign in_x1    = s_tdata[X_BITS+Y_BITS +: X_BITS];
    assign in_y1    = s_tdata[2*X_BITS+Y_BITS +: Y_BITS];
    assign in_color = s_tdata[2*X_BITS+2*Y_BITS +: lrs_pkg::COLOR_W];

    // Start-side deltas
    logic              x_ge, y_ge;
    logic [X_BITS-1:0] st_adx;
    logic [Y_BITS-1:0] st_ady;
    logic [M_BITS-1:0] st_adx_m, st_ady_m;
    logic              st_y_major;

    assign x_ge     = in_x0 >= in_x1;
    assign y_ge     = in_y0 >= in_y1;
    assign st_adx   = x_ge ? (in_x0 - in_x1) : (in_x1 - in_x0);
    assign st_ady   = y_ge ? (in_y0 - in_y1) : (in_y1 - in_y0);
    assign st_adx_m = M_BITS'(st_adx);
    assign st_ady_m = M_BITS'(st_ady);
    assign st_y_major = st_ady_m >= st_adx_m;

    // Step-side increments, from the stored deltas
    logic signed [E_W-1:0] adx_e, ady_e, adx2_e, ady2_e, diag_xm_e, diag_ym_e;
    logic [X_BITS-1:0]     bx_next_x;
    logic [Y_BITS-1:0]     by_next_y;

    assign adx_e     = E_W'(abs_dx_reg);
    assign ady_e     = E_W'(abs_dy_reg);
    assign adx2_e    = adx_e <<< 1;
    assign ady2_e    = ady_e <<< 1;
    assign diag_xm_e = (adx_e - ady_e) <<< 1;   // y-major diagonal move
    assign diag_ym_e = (ady_e - adx_e) <<< 1;   // x-major diagonal move
    assign bx_next_x = dir_x_neg_reg ? (cur_x_reg - X_BITS'(1)) : (cur_x_reg + X_BITS'(1));
    assign by_next_y = dir_y_neg_reg ? (cur_y_reg - Y_BITS'(1)) : (cur_y_reg + Y_BITS'(1));

    // Pixel produced by this request
    logic              emit;
    logic              emit_last;
    logic [X_BITS-1:0] emit_x;
    logic [Y_BITS-1:0] emit_y;

    always_comb begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        end_x_next     = end_x_reg;
        end_y_next     = end_y_reg;
        abs_dx_next    = abs_dx_reg;
        abs_dy_next    = abs_dy_reg;
        err_next       = err_reg;
        dir_x_neg_next = dir_x_neg_reg;
        dir_y_neg_next = dir_y_neg_reg;
        y_major_next   = y_major_reg;
        run_left_next  = run_left_reg;
        kind_next      = kind_reg;
        busy_next      = busy_reg;
        color_next     = color_reg;
        emit           = 1'b0;
        emit_last      = 1'b0;
        emit_x         = cur_x_reg;
        emit_y         = cur_y_reg;

        if (accept) begin
            if (!s_tuser) begin
                // Start: drop any line in flight
                color_next = in_color;
                if (in_y0 == in_y1) begin
                    // Row, drawn from the smaller x, stops short of the larger
                    cur_y_next    = in_y0;
                    cur_x_next    = x_ge ? in_x1 : in_x0;
                    run_left_next = st_adx_m;
                    kind_next     = lrs_pkg::KIND_ROW;
                    busy_next     = st_adx_m != '0;
                end else if (in_x0 == in_x1) begin
                    cur_x_next    = in_x0;
                    cur_y_next    = y_ge ? in_y1 : in_y0;
                    run_left_next = st_ady_m;
                    kind_next     = lrs_pkg::KIND_COL;
                    busy_next     = 1'b1;
                end else begin
                    // Bresenham; first endpoint goes out right away
                    dir_x_neg_next = x_ge;
                    dir_y_neg_next = y_ge;
                    abs_dx_next    = st_adx;
                    abs_dy_next    = st_ady;
                    y_major_next   = st_y_major;
                    err_next       = st_y_major
                                   ? ((E_W'(st_adx) <<< 1) - E_W'(st_ady))
                                   : ((E_W'(st_ady) <<< 1) - E_W'(st_adx));
                    cur_x_next     = in_x0;
                    cur_y_next     = in_y0;
                    end_x_next     = in_x1;
                    end_y_next     = in_y1;
                    run_left_next  = '0;
                    kind_next      = lrs_pkg::KIND_BRES;
                    busy_next      = 1'b1;
                    emit           = 1'b1;
                    emit_x         = in_x0;
                    emit_y         = in_y0;
                end
            end else if (busy_reg) begin
                emit = 1'b1;
                if (kind_reg == lrs_pkg::KIND_ROW || kind_reg == lrs_pkg::KIND_COL) begin
                    // Runs emit the current pixel, then advance
                    run_left_next = run_left_reg - M_BITS'(1);
                    emit_last     = run_left_reg == M_BITS'(1);
                    if (kind_reg == lrs_pkg::KIND_ROW) begin
                        cur_x_next = cur_x_reg + X_BITS'(1);
                    end else begin
                        cur_y_next = cur_y_reg + Y_BITS'(1);
                    end
                end else begin
                    // Bresenham advances first, then emits the new pixel
                    if (y_major_reg) begin
                        emit_y = by_next_y;
                        if (err_reg[E_W-1]) begin
                            err_next = err_reg + adx2_e;
                        end else begin
                            emit_x   = bx_next_x;
                            err_next = err_reg + diag_xm_e;
                        end
                        emit_last = by_next_y == end_y_reg;
                    end else begin
                        emit_x = bx_next_x;
                        if (err_reg[E_W-1]) begin
                            err_next = err_reg + ady2_e;
                        end else begin
                            emit_y   = by_next_y;
                            err_next = err_reg + diag_ym_e;
                        end
                        emit_last = bx_next_x == end_x_reg;
                    end
                    cur_x_next = emit_x;
                    cur_y_next = emit_y;
                end
                if (emit_last) begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            kind_reg <= lrs_pkg::KIND_NONE;
        end else begin
            busy_reg <= busy_next;
            kind_reg <= kind_next;
        end
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        end_x_reg     <= end_x_next;
        end_y_reg     <= end_y_next;
        abs_dx_reg    <= abs_dx_next;
        abs_dy_reg    <= abs_dy_next;
        err_reg       <= err_next;
        dir_x_neg_reg <= dir_x_neg_next;
        dir_y_neg_reg <= dir_y_neg_next;
        y_major_reg   <= y_major_next;
        run_left_reg  <= run_left_next;
        color_reg     <= color_next;
    end

    //------------------------------------------------------------------
    // Stage 1: pixel coordinates
    //------------------------------------------------------------------
    logic [X_BITS-1:0]           p1_x_reg;
    logic [Y_BITS-1:0]           p1_y_reg;
    logic [lrs_pkg::COLOR_W-1:0] p1_color_reg;
    logic                        p1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (p1_en) begin
            p1_valid_reg <= emit;
        end
        if (p1_en) begin
            p1_x_reg     <= emit_x;
            p1_y_reg     <= emit_y;
            p1_color_reg <= color_next;
            p1_last_reg  <= emit_last;
        end
    end

    //------------------------------------------------------------------
    // Stage 2: stride * y and base + x, both mod 2^ADDR_W
    //------------------------------------------------------------------
    logic [PROD_W-1:0]           prod_full;
    logic [lrs_pkg::ADDR_W-1:0]  p2_prod_reg, p2_bx_reg;
    logic [lrs_pkg::COLOR_W-1:0] p2_color_reg;
    logic                        p2_last_reg;

    assign prod_full = PROD_W'(row_stride_reg) * PROD_W'(p1_y_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (p2_en) begin
            p2_valid_reg <= p1_valid_reg;
        end
        if (p2_en) begin
            p2_prod_reg  <= lrs_pkg::ADDR_W'(prod_full);
            p2_bx_reg    <= frame_base_reg + lrs_pkg::ADDR_W'(p1_x_reg);
            p2_color_reg <= p1_color_reg;
            p2_last_reg  <= p1_last_reg;
        end
    end

    //------------------------------------------------------------------
    // Output register
    //------------------------------------------------------------------
    logic [lrs_pkg::ADDR_W-1:0]  m_addr_reg;
    logic [lrs_pkg::COLOR_W-1:0] m_color_reg;
    logic                        m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= p2_valid_reg;
        end
        if (out_en) begin
            m_addr_reg  <= p2_prod_reg + p2_bx_reg;
            m_color_reg <= p2_color_reg;
            m_last_reg  <= p2_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_color_reg, m_addr_reg};
    assign m_tlast  = m_last_reg;

endmodule

### dv/pixel_write_checker.sv
`timescale 1ns / 1ps
// pixel_write_checker: tracks accepted line requests and register writes, predicts each
// pixel write of the line raster stepper and compares it with the pixel write channel.
// Depends on lrs_pkg.
module pixel_write_checker #(
    parameter int X_BITS    = 11,
    parameter int Y_BITS    = 11,
    parameter int S_TDATA_W = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [S_TDATA_W-1:0]           s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [lrs_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           m_tlast,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [lrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lrs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           drain_done,
    output int                             pixels_owed,
    output int                             error_count
);
    import lrs_pkg::*;

    localparam int RUN_W       = (X_BITS > Y_BITS ? X_BITS : Y_BITS) + 1;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_write_t;

    pixel_write_t expected_pixels[$];

    logic [STRIDE_W-1:0] row_stride;
    logic [ADDR_W-1:0]   frame_base;

    logic [X_BITS-1:0]  cur_x, end_x;
    logic [Y_BITS-1:0]  cur_y, end_y;
    logic [RUN_W-1:0]   run_left;
    logic [COLOR_W-1:0] line_color;
    line_kind_t         line_kind;
    logic               dir_x_neg, dir_y_neg, y_major, line_busy;
    int                 err_term, abs_dx, abs_dy;
    logic               drain_checked;

    initial begin
        error_count = 0;
        pixels_owed = 0;
    end

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED)
            $display("%0t ns pixel check: %s", $time, what);
        error_count++;
    endtask

    task automatic queue_pixel(input logic last);
        logic [63:0]  sum;
        pixel_write_t px;
        sum = 64'(frame_base) + 64'(cur_x) + 64'(row_stride) * 64'(cur_y);
        px.addr  = sum[ADDR_W-1:0];
        px.color = line_color;
        px.last  = last;
        expected_pixels.push_back(px);
    endtask

    always @(posedge aclk) begin : track
        pixel_write_t      got, want;
        logic [X_BITS-1:0] x0, x1;
        logic [Y_BITS-1:0] y0, y1;
        logic              last;
        if (!aresetn) begin
            expected_pixels.delete();
            row_stride    = STRIDE_RESET;
            frame_base    = '0;
            cur_x         = '0;
            cur_y         = '0;
            end_x         = '0;
            end_y         = '0;
            run_left      = '0;
            line_color    = '0;
            line_kind     = KIND_NONE;
            dir_x_neg     = 1'b0;
            dir_y_neg     = 1'b0;
            y_major       = 1'b0;
            line_busy     = 1'b0;
            err_term      = 0;
            abs_dx        = 0;
            abs_dy        = 0;
            drain_checked = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.addr  = m_tdata[ADDR_W-1:0];
                got.color = m_tdata[ADDR_W +: COLOR_W];
                got.last  = m_tlast;
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel write addr %h color %h",
                                              got.addr, got.color));
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.addr !== want.addr)
                        report_mismatch($sformatf("address %h, expected %h",
                                                  got.addr, want.addr));
                    if (got.color !== want.color)
                        report_mismatch($sformatf("color %h, expected %h at addr %h",
                                                  got.color, want.color, want.addr));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last flag %b, expected %b at addr %h",
                                                  got.last, want.last, want.addr));
                end
            end

            // unlisted indexes are dropped
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_ROW_STRIDE)
                    row_stride = cfg_data[STRIDE_W-1:0];
                else if (cfg_index == CFG_FRAME_BASE)
                    frame_base = cfg_data[ADDR_W-1:0];
            end

            if (s_tvalid && s_tready) begin
                if (!s_tuser) begin
                    // start: any line in progress is dropped
                    x0         = s_tdata[0 +: X_BITS];
                    y0         = s_tdata[X_BITS +: Y_BITS];
                    x1         = s_tdata[X_BITS + Y_BITS +: X_BITS];
                    y1         = s_tdata[2*X_BITS + Y_BITS +: Y_BITS];
                    line_color = s_tdata[2*X_BITS + 2*Y_BITS +: COLOR_W];
                    line_busy  = 1'b0;
                    line_kind  = KIND_NONE;
                    run_left   = '0;
                    if (y0 == y1) begin
                        // row from the smaller x, stops one short of the larger
                        cur_y     = y0;
                        cur_x     = (x0 <= x1) ? x0 : x1;
                        run_left  = (x0 <= x1) ? RUN_W'(x1 - x0) : RUN_W'(x0 - x1);
                        line_kind = KIND_ROW;
                        line_busy = (run_left != 0);
                    end else if (x0 == x1) begin
                        cur_x     = x0;
                        cur_y     = (y0 <= y1) ? y0 : y1;
                        run_left  = (y0 <= y1) ? RUN_W'(y1 - y0) : RUN_W'(y0 - y1);
                        line_kind = KIND_COL;
                        line_busy = 1'b1;
                    end else begin
                        dir_x_neg = (x0 >= x1);
                        abs_dx    = dir_x_neg ? int'(x0) - int'(x1) : int'(x1) - int'(x0);
                        dir_y_neg = (y0 >= y1);
                        abs_dy    = dir_y_neg ? int'(y0) - int'(y1) : int'(y1) - int'(y0);
                        y_major   = (abs_dy >= abs_dx);
                        err_term  = y_major ? 2*abs_dx - abs_dy : 2*abs_dy - abs_dx;
                        cur_x     = x0;
                        cur_y     = y0;
                        end_x     = x1;
                        end_y     = y1;
                        line_kind = KIND_BRES;
                        line_busy = 1'b1;
                        queue_pixel(1'b0);
                    end
                end else if (line_busy) begin
                    if (line_kind == KIND_ROW || line_kind == KIND_COL) begin
                        run_left = run_left - 1'b1;
                        last     = (run_left == 0);
                        queue_pixel(last);
                        if (line_kind == KIND_ROW)
                            cur_x = cur_x + 1'b1;
                        else
                            cur_y = cur_y + 1'b1;
                    end else begin
                        if (y_major) begin
                            cur_y = dir_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
                            if (err_term < 0) begin
                                err_term += 2*abs_dx;
                            end else begin
                                cur_x = dir_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
                                err_term += 2*(abs_dx - abs_dy);
                            end
                            last = (cur_y == end_y);
                        end else begin
                            cur_x = dir_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
                            if (err_term < 0) begin
                                err_term += 2*abs_dy;
                            end else begin
                                cur_y = dir_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
                                err_term += 2*(abs_dy - abs_dx);
                            end
                            last = (cur_x == end_x);
                        end
                        queue_pixel(last);
                    end
                    if (last)
                        line_busy = 1'b0;
                end
            end

            if (drain_done && !drain_checked) begin
                drain_checked = 1'b1;
                foreach (expected_pixels[i])
                    report_mismatch($sformatf("pixel write never came: addr %h color %h",
                                              expected_pixels[i].addr,
                                              expected_pixels[i].color));
            end
        end
        pixels_owed = expected_pixels.size();
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// tb: top of the line raster stepper testbench. Drives start/step requests, register
// writes and pixel write backpressure, and gives the verdict.
// Depends on lrs_pkg, line_raster_stepper_unit and pixel_write_checker.
module tb;
    import lrs_pkg::*;

    localparam int X_BITS     = 11;
    localparam int Y_BITS     = 11;
    localparam int X_MAX      = (1 << X_BITS) - 1;
    localparam int Y_MAX      = (1 << Y_BITS) - 1;
    localparam int S_TDATA_W  = ((2*X_BITS + 2*Y_BITS + COLOR_W + 7) / 8) * 8;
    localparam int ADDR_MAX   = (1 << ADDR_W) - 1;

    // tuser codes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // indexes past the register list; writes there must leave both registers alone
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    localparam int PHASES             = 8;
    localparam int REQUESTS_PER_PHASE = 195;
    localparam int DRAIN_CYCLES       = 8;       // pipeline is 3 deep, plus margin
    localparam int CYCLE_LIMIT        = 400000;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;   // x_start, y_start, x_end, y_end, color, zero pad
    logic                    s_tuser;   // mode
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;   // pixel_address, pixel_color, zero pad
    logic                    m_tlast;   // last_pixel
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    logic drain_done;
    logic idle_on;         // random gaps and stalls allowed
    int   pixels_owed;
    int   error_count;
    int   requests_sent = 0;
    int   cycle_count = 0;

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    line_raster_stepper_unit #(
        .X_BITS(X_BITS),
        .Y_BITS(Y_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    pixel_write_checker #(
        .X_BITS   (X_BITS),
        .Y_BITS   (Y_BITS),
        .S_TDATA_W(S_TDATA_W)
    ) i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .drain_done (drain_done),
        .pixels_owed(pixels_owed),
        .error_count(error_count)
    );

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Pixel write sink: random bursts of stalls while idling is on.
    initial begin : pixel_sink
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (!idle_on)
                stall_left = 0;
            else if (stall_left != 0)
                stall_left--;
            else if ($urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 14);
            m_tready = (stall_left == 0);
        end
    end

    // One request; called at a falling edge, returns at the falling edge after the
    // handshake. tvalid stays up into the next request unless a gap is drawn.
    task automatic send_request(input logic mode,
                                input logic [X_BITS-1:0] x0, input logic [Y_BITS-1:0] y0,
                                input logic [X_BITS-1:0] x1, input logic [Y_BITS-1:0] y1,
                                input logic [COLOR_W-1:0] color);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = S_TDATA_W'({color, y1, x1, y0, x0});
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        requests_sent++;
    endtask

    // Step request; the endpoint and color fields are don't-care, so fill them at random.
    task automatic send_step();
        send_request(MODE_STEP, X_BITS'($urandom), Y_BITS'($urandom),
                     X_BITS'($urandom), Y_BITS'($urandom), COLOR_W'($urandom));
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Wait for every predicted pixel, then let requests with no pixel (idle steps,
    // row/column starts) fall out of the pipeline before touching registers.
    task automatic settle();
        s_tvalid = 1'b0;
        while (pixels_owed != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Endpoint at a given distance, direction random where both fit; top if neither fits.
    function automatic int offset_coord(input int origin, input int span, input int top);
        int fwd, back;
        fwd  = origin + span;
        back = origin - span;
        if ($urandom_range(0, 1) == 0 && back >= 0) return back;
        if (fwd <= top) return fwd;
        if (back >= 0) return back;
        return top;
    endfunction

    // One line: start plus steps. Mostly short lines run to the end; some get extra
    // steps past the end (idle steps), some are dropped early by the next start.
    task automatic random_line_burst();
        logic [X_BITS-1:0]  x0, x1;
        logic [Y_BITS-1:0]  y0, y1;
        logic [COLOR_W-1:0] color;
        int r, len, dxa, dya, need, steps;
        x0    = X_BITS'($urandom_range(0, X_MAX));
        y0    = Y_BITS'($urandom_range(0, Y_MAX));
        x1    = x0;
        y1    = y0;
        color = COLOR_W'($urandom);
        r = $urandom_range(0, 19);
        if (r < 14)
            len = $urandom_range(1, 12);
        else if (r < 19)
            len = $urandom_range(13, 60);
        else
            len = $urandom_range(61, X_MAX);
        case ($urandom_range(0, 19))
            0, 1, 2, 3: x1 = X_BITS'(offset_coord(x0, len, X_MAX));
            4, 5, 6, 7: y1 = Y_BITS'(offset_coord(y0, len, Y_MAX));
            8, 9, 10, 11, 12: begin
                // shallow
                x1 = X_BITS'(offset_coord(x0, len, X_MAX));
                y1 = Y_BITS'(offset_coord(y0, $urandom_range(1, len), Y_MAX));
            end
            13, 14, 15, 16, 17: begin
                // steep
                y1 = Y_BITS'(offset_coord(y0, len, Y_MAX));
                x1 = X_BITS'(offset_coord(x0, $urandom_range(1, len), X_MAX));
            end
            18: ;  // equal endpoints
            default: begin
                x1 = X_BITS'($urandom_range(0, X_MAX));
                y1 = Y_BITS'($urandom_range(0, Y_MAX));
            end
        endcase
        dxa  = (x1 >= x0) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
        dya  = (y1 >= y0) ? int'(y1) - int'(y0) : int'(y0) - int'(y1);
        need = (dxa > dya) ? dxa : dya;   // steps to finish, any kind of line
        if (need > 60) begin
            steps = $urandom_range(0, 20);
        end else begin
            case ($urandom_range(0, 9))
                8:       steps = need + $urandom_range(1, 3);
                9:       steps = $urandom_range(0, need);
                default: steps = need;
            endcase
        end
        send_request(MODE_START, x0, y0, x1, y1, color);
        repeat (steps) send_step();
    endtask

    initial begin : stimulus
        int   goal;
        logic paused;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = MODE_START;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_ROW_STRIDE;
        cfg_data   = '0;
        drain_done = 1'b0;
        idle_on    = 1'b1;
        paused     = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part, reset register values (stride 640, base 0).
        send_step();                                                // step while idle
        send_request(MODE_START, X_BITS'(0), Y_BITS'(0),            // equal endpoints
                     X_BITS'(0), Y_BITS'(0), 16'h0000);
        send_step();
        send_request(MODE_START, X_BITS'(X_MAX), Y_BITS'(5),        // row, right to left
                     X_BITS'(X_MAX - 3), Y_BITS'(5), 16'hFFFF);
        repeat (3) send_step();
        send_request(MODE_START, X_BITS'(0), Y_BITS'(Y_MAX),        // column, bottom up
                     X_BITS'(0), Y_BITS'(Y_MAX - 2), 16'h8001);
        repeat (2) send_step();
        send_request(MODE_START, X_BITS'(0), Y_BITS'(0),            // shallow
                     X_BITS'(3), Y_BITS'(1), 16'h1234);
        repeat (3) send_step();
        send_request(MODE_START, X_BITS'(X_MAX), Y_BITS'(Y_MAX),    // steep, both neg
                     X_BITS'(X_MAX - 1), Y_BITS'(Y_MAX - 2), 16'hA5A5);
        repeat (2) send_step();
        send_request(MODE_START, X_BITS'(10), Y_BITS'(10),          // 45 deg, steep on the tie
                     X_BITS'(8), Y_BITS'(8), 16'h5A5A);
        repeat (2) send_step();
        send_request(MODE_START, X_BITS'(0), Y_BITS'(Y_MAX),        // corner to corner, dropped
                     X_BITS'(X_MAX), Y_BITS'(0), 16'h7FFF);
        repeat (2) send_step();
        send_request(MODE_START, X_BITS'(0), Y_BITS'(9),            // long row, dropped
                     X_BITS'(X_MAX), Y_BITS'(9), 16'h0001);
        send_step();

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: begin
                    write_register(CFG_ROW_STRIDE, CFG_DATA_W'(1));
                    write_register(CFG_FRAME_BASE, CFG_DATA_W'(ADDR_MAX));
                end
                1: begin
                    write_register(CFG_ROW_STRIDE, CFG_DATA_W'(4096));
                    write_register(CFG_FRAME_BASE, CFG_DATA_W'($urandom_range(0, ADDR_MAX)));
                end
                2: begin
                    // upper data bits fall off: stride 8191
                    write_register(CFG_ROW_STRIDE, CFG_DATA_W'(ADDR_MAX));
                    write_register(CFG_FRAME_BASE, CFG_DATA_W'(0));
                end
                3: begin
                    write_register(CFG_ROW_STRIDE, CFG_DATA_W'($urandom_range(1, 4096)));
                    write_register(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(0, ADDR_MAX)));
                    write_register(CFG_SPARE_HI, CFG_DATA_W'($urandom_range(0, ADDR_MAX)));
                end
                4: begin
                    write_register(CFG_ROW_STRIDE, CFG_DATA_W'(STRIDE_RESET));
                    write_register(CFG_FRAME_BASE, CFG_DATA_W'($urandom_range(0, ADDR_MAX)));
                end
                5: begin
                    write_register(CFG_ROW_STRIDE, CFG_DATA_W'($urandom_range(1, 4096)));
                    write_register(CFG_FRAME_BASE,
                                   CFG_DATA_W'(ADDR_MAX - $urandom_range(0, 4096)));
                end
                default: begin
                    write_register(CFG_ROW_STRIDE, CFG_DATA_W'($urandom_range(1, 4096)));
                    write_register(CFG_FRAME_BASE, CFG_DATA_W'($urandom_range(0, ADDR_MAX)));
                end
            endcase
            idle_on = !(phase == 4 || phase == PHASES - 1);
            goal = requests_sent + REQUESTS_PER_PHASE;
            while (requests_sent < goal) begin
                if (phase == 3 && !paused && requests_sent > goal - REQUESTS_PER_PHASE / 2) begin
                    // hold the sender until every pixel in flight has been written
                    s_tvalid = 1'b0;
                    while (pixels_owed != 0) @(negedge aclk);
                    paused = 1'b1;
                end
                if ($urandom_range(0, 9) != 0)
                    random_line_burst();
                else
                    repeat ($urandom_range(1, 3)) send_step();
            end
        end

        s_tvalid = 1'b0;
        while (pixels_owed != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        drain_done = 1'b1;
        repeat (2) @(negedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
sv/lrs_pkg.sv
sv/line_raster_stepper_unit.sv
dv/pixel_write_checker.sv
dv/tb.sv
